>>> hw/rtl/ppm_pulse_decoder_assert.svh
// Assertion macros shared by the decoder modules.
`ifndef PPM_PULSE_DECODER_ASSERT_SVH
`define PPM_PULSE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define PPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PPM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/ppm_pkg.sv
// Shared types and constants of the pulse-position decoder.
package ppm_pkg;
	localparam int CHANNEL_COUNT_DEF = 6;
	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 8;
	localparam int COUNT_BITS_DEF    = 24;
	localparam int CFG_BITS          = 24;
	localparam int VALUE_BITS        = 25;
	localparam int INDEX_BITS        = 3;

	localparam logic [1:0] REG_SYNC   = 2'd0;
	localparam logic [1:0] REG_CENTER = 2'd1;
	localparam logic [1:0] REG_HIGH   = 2'd2;
	localparam logic [1:0] REG_STEP   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_EDGE,
		ST_OUT
	} ctrl_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic prep;
		logic div_start;
		logic div_step;
		logic edge_upd;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic err;
		logic div_done;
	} dp_status_t;
endpackage

>>> hw/rtl/ppm_if.sv
// Valid/ready channel interface.
interface ppm_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/ppm_ctrl.sv
// Controller state machine of the decoder.
module ppm_ctrl
	import ppm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);
	`include "ppm_pulse_decoder_assert.svh"
	ctrl_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_n = ST_PREP;
			ST_PREP: state_n = status.err ? ST_OUT : ST_DIV;
			ST_DIV: if (status.div_done) state_n = ST_EDGE;
			ST_EDGE: state_n = ST_OUT;
			ST_OUT: if (out_ready) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		out_valid     = (state_q == ST_OUT);
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.prep      = (state_q == ST_PREP) && !status.err;
		cmd.div_start = (state_q == ST_PREP);
		cmd.div_step  = (state_q == ST_DIV) && !status.div_done;
		cmd.edge_upd  = (state_q == ST_EDGE);
	end

	`PPM_ASSERT_IMPL(a_no_both, clk, arst_n, in_ready, !out_valid)
	`PPM_ASSERT_NEXT(a_load_prep, clk, arst_n, cmd.load, state_q == ST_PREP)
	`PPM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

>>> hw/rtl/ppm_dp.sv
// Datapath: extremes, flags, serial divider and edge measurements.
module ppm_dp
	import ppm_pkg::*;
#(
	parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int COUNT_BITS    = COUNT_BITS_DEF
)(
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	output dp_status_t                    status,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          in_err,
	input  logic [CFG_BITS-1:0]           sync_q,
	input  logic [CFG_BITS-1:0]           center_q,
	input  logic [14:0]                   high_q,
	input  logic [15:0]                   step_q,
	output logic                          o_valid,
	output logic [INDEX_BITS-1:0]         o_index,
	output logic signed [VALUE_BITS-1:0]  o_value,
	output logic                          o_clip,
	output logic                          o_low
);
	localparam int SW = SAMPLE_BITS + 3;      // doubled sums and differences
	localparam int TW = COUNT_BITS + FRACTION_BITS + 2;
	localparam int NW = SW + FRACTION_BITS;
	localparam int PW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int DCW = $clog2(FRACTION_BITS + SW + 1);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	logic signed [SAMPLE_BITS-1:0] smp_q, min_q, max_q, prev_q;
	logic                          err_q, clip_q, low_q;
	logic [COUNT_BITS-1:0]         cnt_q [2];
	logic signed [TW-1:0]          start_q [2];
	logic [PW-1:0]                 ptr_q [2];
	logic                          pv_q [2];
	logic signed [VALUE_BITS-1:0]  store_q [CHANNEL_COUNT];
	logic                          rise_q, fall_q;
	logic [NW-1:0]                 quo_q, rem_q;
	logic [SW-1:0]                 den_q;
	logic [DCW-1:0]                dcnt_q;

	logic signed [SAMPLE_BITS-1:0] nmin, nmax;
	logic signed [SW-1:0]          thr2, v1x2, v0x2, num2, den2;
	logic signed [SAMPLE_BITS:0]   diff, mag;

	assign status.err      = err_q;
	assign status.div_done = (dcnt_q == '0);

	always_comb begin
		nmin = (smp_q < min_q) ? smp_q : min_q;
		nmax = (smp_q > max_q) ? smp_q : max_q;
		thr2 = SW'(nmin) + SW'(nmax);
		v1x2 = SW'(smp_q) <<< 1;
		v0x2 = SW'(prev_q) <<< 1;
		num2 = thr2 - v1x2;
		den2 = v1x2 - v0x2;
		diff = (SAMPLE_BITS+1)'(smp_q) - (SAMPLE_BITS+1)'(prev_q);
		mag  = smp_q[SAMPLE_BITS-1] ? -(SAMPLE_BITS+1)'(smp_q) : (SAMPLE_BITS+1)'(smp_q);
	end

	// Restoring divider, one quotient bit per cycle.
	logic [NW:0] trial;
	assign trial = {rem_q[NW-2:0], quo_q[NW-1]} - (NW+1)'(den_q);

	// Edge measurement arithmetic for whichever edge fired.
	logic                 e;
	logic signed [TW-1:0] off, trig, gap, v;
	logic signed [VALUE_BITS-1:0] vs;
	logic signed [VALUE_BITS:0]   msum;
	always_comb begin
		e    = fall_q;
		off  = -TW'(quo_q);
		trig = $signed({2'b00, cnt_q[e], {FRACTION_BITS{1'b0}}}) + off;
		gap  = trig - start_q[e];
		v    = gap - $signed(TW'(center_q));
		if (v > TW'(2**(VALUE_BITS-1)-1)) vs = {1'b0, {(VALUE_BITS-1){1'b1}}};
		else if (v < -TW'(2**(VALUE_BITS-1))) vs = {1'b1, {(VALUE_BITS-1){1'b0}}};
		else vs = v[VALUE_BITS-1:0];
		msum = (VALUE_BITS+1)'(store_q[ptr_q[1]]) + (VALUE_BITS+1)'(vs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			max_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			prev_q <= '0; clip_q <= 1'b0; low_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				cnt_q[i] <= '0; start_q[i] <= '0; ptr_q[i] <= '0; pv_q[i] <= 1'b0;
			end
			for (int i = 0; i < CHANNEL_COUNT; i++) store_q[i] <= '0;
			dcnt_q <= '0; o_valid <= 1'b0;
			smp_q <= '0; err_q <= 1'b0; o_index <= '0; o_value <= '0;
			rise_q <= 1'b0; fall_q <= 1'b0; quo_q <= '0; rem_q <= '0; den_q <= '0;
		end else begin
			if (cmd.load) begin
				smp_q <= in_sample; err_q <= in_err; o_valid <= 1'b0;
				o_index <= '0; o_value <= '0;
				if (in_err)
					for (int i = 0; i < 2; i++) begin
						cnt_q[i] <= '0; start_q[i] <= '0; ptr_q[i] <= '0; pv_q[i] <= 1'b0;
					end
			end
			if (cmd.div_start) begin
				rise_q <= (v0x2 <= thr2) && (v1x2 > thr2);
				fall_q <= (v0x2 >= thr2) && (v1x2 < thr2);
				quo_q  <= NW'(num2[SW-1] ? -num2 : num2) << FRACTION_BITS;
				rem_q  <= '0;
				den_q  <= den2[SW-1] ? -den2 : den2;
				dcnt_q <= ((v0x2 <= thr2) && (v1x2 > thr2)) ||
				          ((v0x2 >= thr2) && (v1x2 < thr2)) ? DCW'(NW) : '0;
			end
			if (cmd.prep) begin
				min_q <= nmin; max_q <= nmax; prev_q <= smp_q;
				if (mag >= $signed({2'b0, high_q})) clip_q <= 1'b1;
				if (diff >= $signed({1'b0, step_q})) low_q <= 1'b1;
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q - 1'b1;
				if (!trial[NW]) begin
					rem_q <= trial[NW-1:0];
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[NW-2:0], quo_q[NW-1]};
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end
			if (cmd.edge_upd) begin
				if (rise_q || fall_q) begin
					if (gap > $signed(TW'(sync_q))) begin
						ptr_q[e] <= '0; pv_q[e] <= 1'b1; start_q[e] <= off;
					end else begin
						start_q[e] <= trig;
						if (pv_q[e]) begin
							if (!e) store_q[ptr_q[0]] <= vs;
							else begin
								o_valid <= 1'b1;
								o_index <= INDEX_BITS'(ptr_q[1]);
								o_value <= msum[VALUE_BITS:1] +
								           VALUE_BITS'(msum[VALUE_BITS] & msum[0]);
							end
							if (32'(ptr_q[e]) == CHANNEL_COUNT - 1) begin
								ptr_q[e] <= '0; pv_q[e] <= 1'b0;
							end else ptr_q[e] <= ptr_q[e] + 1'b1;
						end
					end
				end
				for (int i = 0; i < 2; i++)
					if (cnt_q[i] != CMAX && !((rise_q || fall_q) && e == i[0]
					    && gap > $signed(TW'(sync_q))))
						cnt_q[i] <= cnt_q[i] + 1'b1;
					else if ((rise_q || fall_q) && e == i[0] && gap > $signed(TW'(sync_q)))
						cnt_q[i] <= COUNT_BITS'(1);
			end
		end
	end

	assign o_clip = clip_q;
	assign o_low  = low_q;

	`include "ppm_pulse_decoder_assert.svh"
	`PPM_ASSERT_IMPL(a_one_edge, clk, arst_n, cmd.edge_upd, !(rise_q && fall_q))
	`PPM_ASSERT_NEXT(a_order, clk, arst_n, cmd.prep, min_q <= max_q)
	`PPM_ASSERT_IMPL(a_ptr_range, clk, arst_n, 1'b1, (32'(ptr_q[0]) < CHANNEL_COUNT) && (32'(ptr_q[1]) < CHANNEL_COUNT))
endmodule

>>> hw/rtl/ppm_pulse_decoder.sv
// Top level: PPM decoder, sample in, channel result out.
// Steps from input transfer to result transfer: prep, the divider (one quotient bit per cycle,
// stepping only when the sample crosses the threshold), edge update and output; a stream-error
// item goes from prep straight to output. One item is worked at a time and the next is
// accepted in the cycle after the result transfers.
// arst_n resets extremes, flags, counters, frame pointers, store and registers (config to defaults).
module ppm_pulse_decoder
	import ppm_pkg::*;
#(
	parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int COUNT_BITS    = COUNT_BITS_DEF
)(
	input  logic                clk,
	input  logic                arst_n,
	ppm_if.sink                 in_ch,
	ppm_if.source               out_ch,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);
	logic [CFG_BITS-1:0] sync_q, center_q;
	logic [14:0]         high_q;
	logic [15:0]         step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= 24'd103219; center_q <= 24'd73728;
			high_q <= 15'd29491;  step_q <= 16'd62259;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC:   sync_q <= cfg_data;
				REG_CENTER: center_q <= cfg_data;
				REG_HIGH:   high_q <= cfg_data[14:0];
				REG_STEP:   step_q <= cfg_data[15:0];
				default:    ;
			endcase
		end
	end

	dp_cmd_t    cmd;
	dp_status_t status;
	logic                         o_valid, o_clip, o_low;
	logic [INDEX_BITS-1:0]        o_index;
	logic signed [VALUE_BITS-1:0] o_value;

	ppm_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.status, .cmd
	);

	ppm_dp #(
		.CHANNEL_COUNT(CHANNEL_COUNT), .SAMPLE_BITS(SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS), .COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk, .arst_n, .cmd, .status,
		.in_sample(in_ch.data[SAMPLE_BITS-1:0]), .in_err(in_ch.data[SAMPLE_BITS]),
		.sync_q, .center_q, .high_q, .step_q,
		.o_valid, .o_index, .o_value, .o_clip, .o_low
	);

	assign out_ch.data = {o_low, o_clip, o_value, o_index, o_valid};
endmodule

>>> tb/sv/ppm_pulse_decoder_tb.sv
// Self-checking testbench for the PPM pulse decoder with a built-in channel predictor.
`timescale 1ns / 1ps
module ppm_pulse_decoder_tb;
	import ppm_pkg::*;

	typedef struct packed {
		logic               stream_error;
		logic signed [15:0] sample;
	} sample_item_t;

	typedef struct packed {
		logic                     low_rate_flag;
		logic                     clip_flag;
		logic signed [VALUE_BITS-1:0] channel_value;
		logic [INDEX_BITS-1:0]    channel_index;
		logic                     channel_valid;
	} channel_result_t;

	typedef struct {
		longint count;
		longint start;
		int     ptr;
		bit     framed;
	} edge_timer_t;

	localparam int NCH = CHANNEL_COUNT_DEF;
	localparam int FRAC = FRACTION_BITS_DEF;
	localparam longint VMAX = 64'sd16777215;
	localparam longint VMIN = -64'sd16777216;
	localparam longint CMAX = (64'sd1 << COUNT_BITS_DEF) - 1;

	class ppm_scoreboard;
		longint sync_len = 103219, center_len = 73728, high_lvl = 29491, step_lim = 62259;
		longint run_min = 32767, run_max = -32768, prev_smp = 0;
		bit clip = 0, low_rate = 0;
		edge_timer_t rise_t, fall_t;
		longint rise_store [NCH];
		channel_result_t expected_q [$];
		int mismatches = 0;

		function new();
			clear_timer(rise_t);
			clear_timer(fall_t);
			foreach (rise_store[i]) rise_store[i] = 0;
		endfunction

		function void clear_timer(inout edge_timer_t t);
			t.count = 0;
			t.start = 0;
			t.ptr = 0;
			t.framed = 0;
		endfunction

		function void set_reg(logic [1:0] idx, longint val);
			case (idx)
				REG_SYNC:   sync_len = val & 24'hFFFFFF;
				REG_CENTER: center_len = val & 24'hFFFFFF;
				REG_HIGH:   high_lvl = val & 15'h7FFF;
				REG_STEP:   step_lim = val & 16'hFFFF;
				default: ;
			endcase
		endfunction

		// Times one crossing; returns the channel index or -1.
		function int time_crossing(inout edge_timer_t t, input longint num2, input longint den2,
				output longint val);
			longint an, ad, offset, trig, gap;
			int idx;
			idx = -1;
			val = 0;
			an = num2 < 0 ? -num2 : num2;
			ad = den2 < 0 ? -den2 : den2;
			offset = -((an << FRAC) / ad);
			trig = (t.count << FRAC) + offset;
			gap = trig - t.start;
			t.start = trig;
			if (gap > sync_len) begin
				t.ptr = 0;
				t.framed = 1;
				t.count = 0;
				t.start = offset;
			end else if (t.framed) begin
				val = gap - center_len;
				if (val > VMAX) val = VMAX;
				if (val < VMIN) val = VMIN;
				idx = t.ptr;
				t.ptr++;
				if (t.ptr >= NCH) begin
					t.ptr = 0;
					t.framed = 0;
				end
			end
			return idx;
		endfunction

		function void note_input(sample_item_t it);
			channel_result_t e;
			longint v1, v0, thr2, diff, mag, val, mean;
			int idx;
			e = '0;
			if (it.stream_error) begin
				clear_timer(rise_t);
				clear_timer(fall_t);
			end else begin
				v1 = it.sample;
				v0 = prev_smp;
				if (v1 < run_min) run_min = v1;
				if (v1 > run_max) run_max = v1;
				thr2 = run_max + run_min;
				diff = v1 - v0;
				mag = v1 < 0 ? -v1 : v1;
				if (mag >= high_lvl) clip = 1;
				if (diff >= step_lim) low_rate = 1;
				if (2 * v0 <= thr2 && 2 * v1 > thr2) begin
					idx = time_crossing(rise_t, thr2 - 2 * v1, 2 * diff, val);
					if (idx >= 0) rise_store[idx] = val;
				end
				if (2 * v0 >= thr2 && 2 * v1 < thr2) begin
					idx = time_crossing(fall_t, thr2 - 2 * v1, 2 * diff, val);
					if (idx >= 0) begin
						mean = (rise_store[idx] + val) / 2;
						e.channel_valid = 1;
						e.channel_index = idx[INDEX_BITS-1:0];
						e.channel_value = mean[VALUE_BITS-1:0];
					end
				end
				if (rise_t.count < CMAX) rise_t.count++;
				if (fall_t.count < CMAX) fall_t.count++;
				prev_smp = v1;
			end
			e.clip_flag = clip;
			e.low_rate_flag = low_rate;
			expected_q.push_back(e);
		endfunction

		function void check_result(channel_result_t got);
			channel_result_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			e = expected_q.pop_front();
			if (got.channel_valid !== e.channel_valid || got.channel_index !== e.channel_index ||
					got.channel_value !== e.channel_value || got.clip_flag !== e.clip_flag ||
					got.low_rate_flag !== e.low_rate_flag) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p, got %p", e, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	ppm_if #(.W($bits(sample_item_t))) in_ch ();
	ppm_if #(.W($bits(channel_result_t))) out_ch ();

	ppm_pulse_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ppm_scoreboard sb = new();
	bit calm = 0;
	bit hold_req = 0;
	int sent = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("ppm_pulse_decoder_tb: errors");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
			if (hold_req) begin
				hold_req = 0;
				out_ch.ready <= 0;
				repeat (400) @(posedge clk);
			end else if (calm) begin
				out_ch.ready <= 1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 0;
			end else if ($urandom_range(0, 9) < 7) begin
				out_ch.ready <= 1;
			end else begin
				stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 80);
				out_ch.ready <= 0;
			end
		end
	end

	task automatic send_item(int smp, logic err);
		sample_item_t it;
		int gap;
		it.sample = 16'(smp);
		it.stream_error = err;
		gap = 0;
		if (!calm) begin
			if ($urandom_range(0, 9) >= 6)
				gap = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		end
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(it);
		sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_regs(int syn, int ctr, int hi, int stp);
		write_reg(REG_SYNC, CFG_BITS'(syn));
		write_reg(REG_CENTER, CFG_BITS'(ctr));
		write_reg(REG_HIGH, CFG_BITS'(hi));
		write_reg(REG_STEP, CFG_BITS'(stp));
	endtask

	// One frame: a long low stretch, then seven short high pulses with random gaps.
	task automatic send_frame(int sync_samples, int center_samples);
		int lo, hi, w, g;
		lo = -$urandom_range(5000, 30000);
		hi = $urandom_range(5000, 30000);
		repeat (sync_samples + $urandom_range(2, 6))
			send_item(lo + $urandom_range(0, 800) - 400, 1'b0);
		for (int k = 0; k < 7; k++) begin
			w = $urandom_range(1, 3);
			g = center_samples + $urandom_range(0, 10) - 6;
			if (g < 2) g = 2;
			repeat (w) send_item(hi + $urandom_range(0, 800) - 400, 1'b0);
			repeat (g) send_item(lo + $urandom_range(0, 800) - 400, 1'b0);
			if ($urandom_range(0, 39) == 0) send_item($urandom, 1'b1);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_SYNC;
		cfg_data = '0;
		in_ch.valid = 0;
		in_ch.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, threshold straddles, stream errors, flag triggers.
		calm = 1;
		send_item(16'sh0000, 1'b0);
		send_item(-16'sd32768, 1'b0);
		send_item(16'sd32767, 1'b0);
		send_item(-16'sd32768, 1'b0);
		send_item(-16'sd1, 1'b0);
		send_item(16'sd1, 1'b0);
		send_item(16'sh5A5A, 1'b1);
		send_item(16'sd32767, 1'b0);
		send_item(-16'sd2, 1'b0);
		send_item(16'sd0, 1'b0);
		send_item(16'sh7FFF, 1'b1);
		send_item(16'sd100, 1'b0);
		send_item(-16'sd100, 1'b0);
		calm = 0;
		drain();

		set_regs(20 * 256, 10 * 256, 29491, 1000);
		send_frame(20, 10);
		hold_req = 1;
		repeat (30) send_item($urandom, $urandom_range(0, 19) == 0);
		// Sender pause until every pending result is back.
		drain();
		calm = 1;
		send_frame(20, 10);
		calm = 0;
		while (sent < 300) begin
			if ($urandom_range(0, 4) != 0) send_frame(20, 10);
			else repeat ($urandom_range(3, 15)) send_item($urandom, $urandom_range(0, 9) == 0);
		end
		drain();

		set_regs(0, 0, 32767, 65535);
		send_frame(4, 6);
		send_item(-16'sd32768, 1'b0);
		send_item(16'sd32767, 1'b0);
		drain();

		set_regs(24'hFFFFFF, 24'hFFFFFF, 0, 0);
		send_frame(2, 6);
		drain();

		set_regs(12 * 256, 24'hFFFFFF, 20000, 30000);
		send_frame(12, 6);
		send_frame(12, 6);
		drain();

		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("ppm_pulse_decoder_tb: clean");
		else
			$display("ppm_pulse_decoder_tb: errors");
		$finish;
	end
endmodule
